FILE: rtl/core/fbpe_pkg.sv
// ----------------------------------------------------------------------------
// fbpe_pkg
// Shared types, codes and the byte mask helper for the framebuffer pixel engine.
// ----------------------------------------------------------------------------
package fbpe_pkg;

  // operation codes carried in the input word's tuser
  localparam logic [1:0] FN_PUT   = 2'd0;
  localparam logic [1:0] FN_GET   = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MUL,
    S_READ,
    S_MODIFY,
    S_DONE
  } fbpe_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       color;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
  } item_t;

  typedef struct packed {
    logic pixel_value;
    logic status;
  } res_t;

  // Mask of n pixels starting at bit_pos, counted from the MSB.
  function automatic logic [7:0] clr_mask(logic [2:0] bit_pos, logic [3:0] n);
    logic [3:0] stop;
    stop = {1'b0, bit_pos} + n;
    return (8'hFF >> bit_pos) & ~(8'hFF >> stop);
  endfunction

endpackage

FILE: rtl/core/mono_framebuffer_pixel_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_engine
// One-bit-per-pixel bitmap with put, get and clipped rectangle clear.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pixel store to zero, one byte a cycle,
// over all (MAX_WIDTH*MAX_HEIGHT+7)/8 bytes (1024 at the defaults) and holds
// in_tready low meanwhile; configuration writes are taken at any time. One
// word is worked at a time through a single read-modify-write port on the byte
// store. Put and get pass through accept, address multiply, read, modify and
// result steps; the result loads into the output register in the result step
// and the next word is taken the cycle after. A rectangle clear does one read
// and one masked write per byte touched along each clipped row; an error goes
// from accept straight to result, an empty rectangle from multiply to result.
// A result step stretches while the output register holds an unaccepted word.
// A finished result waits in the output register while the next word is accepted.
module mono_framebuffer_pixel_engine #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [fbpe_pkg::IN_DATA_W-1:0] in_tdata,   // pos_x[7:0], pos_y[15:8], color[16],
                                  // rect_width[24:17], rect_height[32:25], zero
  input  logic [1:0]  in_tuser,   // func[1:0]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [fbpe_pkg::OUT_DATA_W-1:0] out_tdata,  // pixel_value[0], zero
  output logic        out_tuser,  // status[0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  import fbpe_pkg::*;

  localparam int WW          = $clog2(MAX_WIDTH + 1);
  localparam int HW          = $clog2(MAX_HEIGHT + 1);
  localparam int CWW         = (WW > 8) ? WW : 8;
  localparam int CHW         = (HW > 7) ? HW : 7;
  localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 7) / 8;
  localparam int BAW         = $clog2(STORE_BYTES);

  logic [7:0]     canvas_width_r;
  logic [6:0]     canvas_height_r;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  item_t          in_item;
  res_t           res, out_res_r;
  logic           out_valid_r;
  logic           out_free;
  logic           res_load;
  logic           mem_we;
  logic [BAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= 8'd128;
      canvas_height_r <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // saturate to the store geometry
  assign w_eff = (CWW'(canvas_width_r) > CWW'(MAX_WIDTH)) ?
                 WW'(MAX_WIDTH) : WW'(canvas_width_r);
  assign h_eff = (CHW'(canvas_height_r) > CHW'(MAX_HEIGHT)) ?
                 HW'(MAX_HEIGHT) : HW'(canvas_height_r);

  assign in_item.func        = in_tuser;
  assign in_item.pos_x       = in_tdata[7:0];
  assign in_item.pos_y       = in_tdata[15:8];
  assign in_item.color       = in_tdata[16];
  assign in_item.rect_width  = in_tdata[24:17];
  assign in_item.rect_height = in_tdata[32:25];

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.pixel_value};
  assign out_tuser  = out_res_r.status;

  fbpe_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW),
    .STORE_BYTES(STORE_BYTES),
    .BAW        (BAW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fbpe_store #(
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

FILE: rtl/core/fbpe_store.sv
// ----------------------------------------------------------------------------
// fbpe_store
// Byte-wide pixel memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbpe_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/fbpe_ctrl.sv
// ----------------------------------------------------------------------------
// fbpe_ctrl
// Sequencer and shared address/mask unit: clearing pass, address multiply,
// clipping, and read-modify-write of one byte per pass.
// ----------------------------------------------------------------------------
module fbpe_ctrl #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1),
  parameter int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 7) / 8,
  parameter int BAW        = $clog2(STORE_BYTES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WW-1:0]      w_eff,
  input  logic [HW-1:0]      h_eff,
  input  logic               in_valid,
  output logic               in_ready,
  input  fbpe_pkg::item_t    in_item,
  input  logic               out_free,
  output logic               res_load,
  output fbpe_pkg::res_t     res,
  output logic               mem_we,
  output logic [BAW-1:0]     mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic [BAW-1:0]     mem_raddr,
  input  logic [7:0]         mem_rdata
);

  import fbpe_pkg::*;

  localparam int AW = BAW + 3;
  localparam int XW = (WW > 8) ? WW : 8;
  localparam int YW = (HW > 8) ? HW : 8;
  localparam int PW = 8 + WW;

  fbpe_state_t    state_r, state_nxt;
  item_t          item_r, item_nxt;
  res_t           res_r, res_nxt;
  logic [AW-1:0]  cur_addr_r, cur_addr_nxt;
  logic [AW-1:0]  row_addr_r, row_addr_nxt;
  logic [7:0]     count_r, count_nxt;
  logic [7:0]     rw_r, rw_nxt;
  logic [7:0]     lines_r, lines_nxt;
  logic [BAW-1:0] init_addr_r, init_addr_nxt;

  logic           in_err;
  logic [PW-1:0]  prod_sum;
  logic [XW-1:0]  rw_lim;
  logic [YW-1:0]  rh_lim;
  logic [7:0]     rw_c, rh_c;
  logic [2:0]     bit_pos;
  logic [3:0]     avail, run_n;
  logic [7:0]     pmask, cmask;

  assign in_err = (in_item.func == FN_RSVD) ||
                  (XW'(in_item.pos_x) >= XW'(w_eff)) ||
                  (YW'(in_item.pos_y) >= YW'(h_eff));

  // shared multiplier: bit address of the first pixel
  assign prod_sum = PW'(item_r.pos_y) * PW'(w_eff) + PW'(item_r.pos_x);

  // clip to the canvas; origin is known to be inside
  assign rw_lim = XW'(w_eff) - XW'(item_r.pos_x);
  assign rh_lim = YW'(h_eff) - YW'(item_r.pos_y);
  assign rw_c = (XW'(item_r.rect_width) > rw_lim) ? rw_lim[7:0] : item_r.rect_width;
  assign rh_c = (YW'(item_r.rect_height) > rh_lim) ? rh_lim[7:0] : item_r.rect_height;

  assign bit_pos = cur_addr_r[2:0];
  assign avail   = 4'd8 - {1'b0, bit_pos};
  assign run_n   = ({4'd0, avail} > count_r) ? count_r[3:0] : avail;
  assign pmask   = 8'h80 >> bit_pos;
  assign cmask   = clr_mask(bit_pos, run_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
    end else begin
      init_addr_r <= init_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    cur_addr_r <= cur_addr_nxt;
    row_addr_r <= row_addr_nxt;
    count_r    <= count_nxt;
    rw_r       <= rw_nxt;
    lines_r    <= lines_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    cur_addr_nxt  = cur_addr_r;
    row_addr_nxt  = row_addr_r;
    count_nxt     = count_r;
    rw_nxt        = rw_r;
    lines_nxt     = lines_r;
    init_addr_nxt = init_addr_r;
    in_ready      = 1'b0;
    res_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cur_addr_r[AW-1:3];
    mem_wdata     = mem_rdata;
    mem_raddr     = cur_addr_r[AW-1:3];

    case (state_r)
      S_INIT: begin
        // sweep the store to zero after reset
        mem_we        = 1'b1;
        mem_waddr     = init_addr_r;
        mem_wdata     = 8'h00;
        init_addr_nxt = init_addr_r + 1'b1;
        if (init_addr_r == BAW'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt            = in_item;
          res_nxt.pixel_value = 1'b0;
          res_nxt.status      = in_err;
          state_nxt           = in_err ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cur_addr_nxt = AW'(prod_sum);
        row_addr_nxt = AW'(prod_sum);
        count_nxt    = rw_c;
        rw_nxt       = rw_c;
        lines_nxt    = rh_c;
        if (item_r.func == FN_CLEAR && (rw_c == 8'd0 || rh_c == 8'd0)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        case (item_r.func)
          FN_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = item_r.color ? (mem_rdata | pmask) : (mem_rdata & ~pmask);
            state_nxt = S_DONE;
          end
          FN_GET: begin
            res_nxt.pixel_value = |(mem_rdata & pmask);
            state_nxt           = S_DONE;
          end
          default: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~cmask;
            if (count_r == {4'd0, run_n}) begin
              if (lines_r == 8'd1) begin
                state_nxt = S_DONE;
              end else begin
                // advance to the next row of the rectangle
                lines_nxt    = lines_r - 8'd1;
                row_addr_nxt = row_addr_r + AW'(w_eff);
                cur_addr_nxt = row_addr_r + AW'(w_eff);
                count_nxt    = rw_r;
                state_nxt    = S_READ;
              end
            end else begin
              cur_addr_nxt = cur_addr_r + AW'(run_n);
              count_nxt    = count_r - {4'd0, run_n};
              state_nxt    = S_READ;
            end
          end
        endcase
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("store written while idle");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_waddr} < (BAW + 1)'(STORE_BYTES)))
    else $error("store write beyond depth");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && item_r.func == FN_CLEAR) |-> count_r != 8'd0)
    else $error("clear run started with zero count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded over a pending word");

  a_point_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODIFY && item_r.func != FN_CLEAR) |=> state_r == S_DONE)
    else $error("pixel access did not finish after one byte");
`endif

endmodule

FILE: test/mono_framebuffer_pixel_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_engine_test
// Self-checking bench for the bitmap pixel engine. A short table of directed
// words, followed by random put/get/clear/reserved traffic over several
// canvas sizes and idle patterns. Every accepted word is run through a bit-level
// shadow of the bitmap, and each result word is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module mono_framebuffer_pixel_engine_test;
  import fbpe_pkg::*;

  localparam int MAX_W = 128;
  localparam int MAX_H = 64;
  localparam int STORE_BYTES = (MAX_W * MAX_H + 7) / 8;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    TR_NONE,
    TR_SEND,
    TR_RECV,
    TR_BOTH
  } traffic_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
    logic [7:0] rw;
    logic [7:0] rh;
    logic       typed;
    logic       pix;
    logic       status;
  } dir_row_t;

  typedef struct {
    item_t it;
    res_t  res;
  } pending_t;

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{FN_GET,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_PUT,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_GET,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{FN_PUT,   8'd127, 8'd63,  1'b1, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
    '{FN_GET,   8'd127, 8'd63,  1'b1, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0},
    '{FN_PUT,   8'd128, 8'd0,   1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 1'b1},
    '{FN_GET,   8'd0,   8'd64,  1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 1'b1},
    '{FN_GET,   8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1},
    '{FN_RSVD,  8'd0,   8'd0,   1'b1, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1},
    '{FN_PUT,   8'd7,   8'd0,   1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_PUT,   8'd8,   8'd0,   1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_CLEAR, 8'd0,   8'd0,   1'b0, 8'd0,   8'd255, 1'b1, 1'b0, 1'b0},
    '{FN_CLEAR, 8'd0,   8'd0,   1'b0, 8'd255, 8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_GET,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{FN_CLEAR, 8'd128, 8'd0,   1'b0, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1},
    '{FN_CLEAR, 8'd0,   8'd64,  1'b0, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1},
    '{FN_CLEAR, 8'd3,   8'd0,   1'b0, 8'd5,   8'd1,   1'b1, 1'b0, 1'b0},
    '{FN_GET,   8'd7,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{FN_GET,   8'd8,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{FN_PUT,   8'd126, 8'd62,  1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_CLEAR, 8'd100, 8'd50,  1'b0, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
    '{FN_GET,   8'd126, 8'd62,  1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{FN_GET,   8'd127, 8'd63,  1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    '{FN_PUT,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
    '{FN_GET,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = FN_PUT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_CANVAS_WIDTH;
  logic [7:0]  cfg_data = '0;

  // shadow bitmap and canvas registers
  logic [7:0]  pix_bytes [STORE_BYTES];
  int unsigned canvas_w = 128;
  int unsigned canvas_h = 64;

  pending_t    result_q [$];
  int          fail_count = 0;
  int          mism_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asked = 0;
  int          hold_given = 0;
  int          hold_left = 0;
  logic [7:0]  last_px = '0;
  logic [7:0]  last_py = '0;
  int          n_put = 0, n_get = 0, n_clear = 0, n_rej = 0, n_ones = 0;
  int          n_settings = 1;

  mono_framebuffer_pixel_engine #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned eff_w();
    return (canvas_w > MAX_W) ? MAX_W : canvas_w;
  endfunction

  function automatic int unsigned eff_h();
    return (canvas_h > MAX_H) ? MAX_H : canvas_h;
  endfunction

  // Apply one word to the shadow bitmap and return the result it produces.
  function automatic res_t apply_pixel_op(item_t it);
    res_t        r;
    int unsigned w, h, x, y, rw, rh, a;
    r  = '0;
    w  = eff_w();
    h  = eff_h();
    x  = it.pos_x;
    y  = it.pos_y;
    rw = it.rect_width;
    rh = it.rect_height;
    if (it.func == FN_RSVD || x >= w || y >= h) begin
      r.status = 1'b1;
    end else if (it.func == FN_PUT || it.func == FN_GET) begin
      a = y * w + x;
      if (it.func == FN_PUT) begin
        pix_bytes[a >> 3][7 - (a & 7)] = it.color;
      end else begin
        r.pixel_value = pix_bytes[a >> 3][7 - (a & 7)];
      end
    end else begin
      // clip to canvas, then clear pixel by pixel
      if (x + rw > w) rw = w - x;
      if (y + rh > h) rh = h - y;
      for (int unsigned ln = 0; ln < rh; ln++) begin
        for (int unsigned c = 0; c < rw; c++) begin
          a = (y + ln) * w + x + c;
          pix_bytes[a >> 3][7 - (a & 7)] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    int unsigned w, h, pick;
    w    = eff_w();
    h    = eff_h();
    pick = $urandom_range(99);
    it.func = (pick < 40) ? FN_PUT : (pick < 70) ? FN_GET : (pick < 95) ? FN_CLEAR : FN_RSVD;
    it.pos_x = (w > 0 && $urandom_range(99) < 85) ? 8'($urandom_range(w - 1))
                                                   : 8'($urandom_range(255));
    it.pos_y = (h > 0 && $urandom_range(99) < 85) ? 8'($urandom_range(h - 1))
                                                   : 8'($urandom_range(255));
    // revisit the last put so gets see set pixels
    if (it.func == FN_GET && $urandom_range(99) < 40) begin
      it.pos_x = last_px;
      it.pos_y = last_py;
    end
    it.color = ($urandom_range(99) < 70);
    // keep most rectangles small; a full sweep is slow
    if (it.func == FN_CLEAR && $urandom_range(99) < 90) begin
      it.rect_width  = 8'($urandom_range(12));
      it.rect_height = 8'($urandom_range(12));
    end else begin
      it.rect_width  = 8'($urandom_range(255));
      it.rect_height = 8'($urandom_range(255));
    end
    return it;
  endfunction

  task automatic set_traffic(traffic_t tr);
    send_idle_pct  = (tr == TR_SEND) ? 86 : (tr == TR_BOTH) ? 7 : 0;
    recv_stall_pct = (tr == TR_RECV) ? 86 : (tr == TR_BOTH) ? 7 : 0;
  endtask

  task automatic send_word(item_t it, bit typed, res_t given);
    pending_t p;
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {7'b0, it.rect_height, it.rect_width, it.color, it.pos_y, it.pos_x};
    do @(posedge clk); while (!in_tready);
    p.it  = it;
    p.res = apply_pixel_op(it);
    if (typed) p.res = given;
    result_q.push_back(p);
    if (p.res.status) n_rej++;
    else if (it.func == FN_PUT) n_put++;
    else if (it.func == FN_GET) n_get++;
    else n_clear++;
    if (p.res.pixel_value) n_ones++;
    if (it.func == FN_PUT) begin
      last_px = it.pos_x;
      last_py = it.pos_y;
    end
  endtask

  // drop valid only when it is still up, so a word sent right after gets one update
  task automatic drain();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Write both canvas registers back to back, holding valid across them.
  task automatic write_canvas(logic [7:0] w, logic [7:0] h);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    canvas_w = w;
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    canvas_h = h & 8'h7F;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_burst(int count, int pause_at);
    for (int k = 0; k < count; k++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      if (k == pause_at) drain();
      send_word(rand_item(), 1'b0, '0);
    end
  endtask

  // result side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pending_t p;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        fail_count++;
        if (mism_count < MAX_REPORTS)
          $display("unexpected result word: tdata=%h tuser=%b", out_tdata, out_tuser);
        mism_count++;
      end else begin
        p = result_q.pop_front();
        if (out_tdata !== {7'b0, p.res.pixel_value} || out_tuser !== p.res.status) begin
          fail_count++;
          if (mism_count < MAX_REPORTS) begin
            $display("mismatch func=%0d x=%0d y=%0d c=%0d rw=%0d rh=%0d:",
                     p.it.func, p.it.pos_x, p.it.pos_y, p.it.color, p.it.rect_width,
                     p.it.rect_height);
            $display("  exp pix=%b st=%b, got tdata=%h st=%b",
                     p.res.pixel_value, p.res.status, out_tdata, out_tuser);
          end
          mism_count++;
        end
      end
    end
  end

  initial begin
    item_t    it;
    dir_row_t row;
    res_t     given;
    for (int i = 0; i < STORE_BYTES; i++) pix_bytes[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed words on the reset canvas
    set_traffic(TR_NONE);
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TAB[i];
      it.func        = row.func;
      it.pos_x       = row.x;
      it.pos_y       = row.y;
      it.color       = row.color;
      it.rect_width  = row.rw;
      it.rect_height = row.rh;
      given.pixel_value = row.pix;
      given.status      = row.status;
      send_word(it, row.typed, given);
    end
    run_burst(75, -1);

    // oversized registers saturate to the maximum canvas
    write_canvas(8'd255, 8'd127);
    set_traffic(TR_SEND);
    run_burst(95, -1);

    // narrow canvas, width not a multiple of eight
    write_canvas(8'd13, 8'd5);
    set_traffic(TR_RECV);
    run_burst(95, -1);

    write_canvas(8'd1, 8'd1);
    set_traffic(TR_BOTH);
    run_burst(60, -1);

    // zero canvas: everything rejected
    write_canvas(8'd0, 8'd0);
    set_traffic(TR_NONE);
    run_burst(30, -1);

    // full canvas with the height top bit set; hold the output to back up the input
    write_canvas(8'd128, 8'hC0);
    hold_asked++;
    run_burst(95, -1);

    write_canvas(8'd100, 8'd37);
    set_traffic(TR_SEND);
    run_burst(95, 50);

    write_canvas(8'd8, 8'd8);
    set_traffic(TR_RECV);
    run_burst(95, -1);

    write_canvas(8'd77, 8'd127);
    set_traffic(TR_BOTH);
    run_burst(95, -1);

    write_canvas(8'd128, 8'd0);
    set_traffic(TR_NONE);
    run_burst(20, -1);

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d put, %0d get (%0d set), %0d clear, %0d rejected words",
             n_put, n_get, n_ones, n_clear, n_rej);
    $display("over %0d canvas settings, idle/stall/hold/drain phases; %0d mismatches",
             n_settings, mism_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
